FILE: rtl/core/rgbhsv_pkg.sv
// Package for the RGB to HSV converter: channel and hue widths, divider sizing,
// the hue sector type and the side-band struct that rides along the pipeline.
// No dependencies.
package rgbhsv_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int FS           = (1 << CHANNEL_BITS) - 1;

    localparam int HUE_BITS  = 15;
    localparam int HUE_SIXTH = 3840;   // 60 degrees in 1/64 degree units
    localparam int HUE_FULL  = 23040;  // 360 degrees
    localparam int TERM_BITS = 12;     // sector term is at most HUE_SIXTH

    // divider sizing: quotient covers both the hue term and saturation
    localparam int Q_BITS   = (CHANNEL_BITS > TERM_BITS) ? CHANNEL_BITS : TERM_BITS;
    localparam int DEN_BITS = CHANNEL_BITS + 1;
    localparam int NUM_BITS = Q_BITS + DEN_BITS;

    // input stage, delta stage, numerator stage, divider stages, output stage
    localparam int PIPE_DEPTH = Q_BITS + 4;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } t_sector;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] mx;
        t_sector                 sect;
        logic                    neg;
        logic                    undef;
    } t_side;

endpackage

FILE: rtl/core/rgbhsv_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on rgbhsv_pkg for NUM_BITS, DEN_BITS and Q_BITS.
module rgbhsv_div (
    input  logic                           i_clk,
    input  logic [rgbhsv_pkg::NUM_BITS-1:0] i_num,
    input  logic [rgbhsv_pkg::DEN_BITS-1:0] i_den,
    output logic [rgbhsv_pkg::Q_BITS-1:0]   o_quo,
    output logic                           o_rem_nz
);

    localparam int NB = rgbhsv_pkg::NUM_BITS;
    localparam int DB = rgbhsv_pkg::DEN_BITS;
    localparam int QB = rgbhsv_pkg::Q_BITS;

    logic [NB-1:0] r_rem [QB];
    logic [DB-1:0] r_den [QB-1];
    logic [QB-1:0] r_quo [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int BIT = QB - 1 - k;
        logic [NB-1:0] n_rem_in;
        logic [DB-1:0] n_den_in;
        logic [QB-1:0] n_quo_in;
        logic [NB-1:0] n_den_sh;
        logic          n_take;

        if (k == 0) begin : g_first
            assign n_rem_in = i_num;
            assign n_den_in = i_den;
            assign n_quo_in = '0;
        end else begin : g_next
            assign n_rem_in = r_rem[k-1];
            assign n_den_in = r_den[k-1];
            assign n_quo_in = r_quo[k-1];
        end

        assign n_den_sh = NB'(n_den_in) << BIT;
        assign n_take   = (n_rem_in >= n_den_sh);

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_take ? (n_rem_in - n_den_sh) : n_rem_in;
            r_quo[k] <= n_quo_in | (n_take ? (QB'(1) << BIT) : QB'(0));
        end

        if (k < QB - 1) begin : g_den
            always_ff @(posedge i_clk) begin
                r_den[k] <= n_den_in;
            end
        end
    end

    assign o_quo    = r_quo[QB-1];
    assign o_rem_nz = |r_rem[QB-1];

endmodule

FILE: rtl/core/rgb_to_hsv_converter_core.sv
// Top level of the RGB to HSV converter: min/max, sector select, numerators,
// two pipelined dividers and the hue wrap. Depends on rgbhsv_pkg, rgbhsv_div.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+------------------------------------
//  pixel in  | input     | start, busy             | i_red, i_green, i_blue
//  HSV out   | output    | o_valid (1-cycle pulse) | o_hue, o_hue_undefined,
//            |           |                         | o_saturation, o_brightness
//
// One pixel per clock while busy is low, fully pipelined through 16 register stages
// (3 front stages, 12 divider stages, 1 output stage): o_valid rises as the result
// leaves the output stage, and the result transaction is taken in that strobe cycle.
// The divider depth is one stage per quotient bit, sized by the hue term.
// busy is high only during reset; the pipeline never stalls and the receiver
// takes every result in its strobe cycle.
// Reset (synchronous) clears the valid bits only; payload registers are free.
module rgb_to_hsv_converter_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [rgbhsv_pkg::CHANNEL_BITS-1:0] i_red,
    input  logic [rgbhsv_pkg::CHANNEL_BITS-1:0] i_green,
    input  logic [rgbhsv_pkg::CHANNEL_BITS-1:0] i_blue,
    output logic                               o_valid,
    output logic [rgbhsv_pkg::HUE_BITS-1:0]     o_hue,
    output logic                               o_hue_undefined,
    output logic [rgbhsv_pkg::CHANNEL_BITS-1:0] o_saturation,
    output logic [rgbhsv_pkg::CHANNEL_BITS-1:0] o_brightness
);

    localparam int CB = rgbhsv_pkg::CHANNEL_BITS;
    localparam int HB = rgbhsv_pkg::HUE_BITS;
    localparam int NB = rgbhsv_pkg::NUM_BITS;
    localparam int DB = rgbhsv_pkg::DEN_BITS;
    localparam int QB = rgbhsv_pkg::Q_BITS;
    localparam int PD = rgbhsv_pkg::PIPE_DEPTH;

    // valid bits, one per stage: 0 = A, 1 = B, 2 = C, 3.. = divider, last = output
    logic [PD-1:0] r_vld;

    assign busy = ~i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PD-2:0], start & ~busy};
        end
    end

    // ---------------- stage A: max, min, sector, difference pair ----------------
    logic [CB-1:0]       n_mx, n_mn, n_p, n_n;
    rgbhsv_pkg::t_sector n_sect;

    always_comb begin
        // red wins ties, then green
        priority if (i_red >= i_green && i_red >= i_blue) begin
            n_mx   = i_red;
            n_sect = rgbhsv_pkg::SECT_RED;
            n_p    = i_green;
            n_n    = i_blue;
        end else if (i_green >= i_blue) begin
            n_mx   = i_green;
            n_sect = rgbhsv_pkg::SECT_GREEN;
            n_p    = i_blue;
            n_n    = i_red;
        end else begin
            n_mx   = i_blue;
            n_sect = rgbhsv_pkg::SECT_BLUE;
            n_p    = i_red;
            n_n    = i_green;
        end
        n_mn = i_red;
        if (i_green < n_mn) n_mn = i_green;
        if (i_blue < n_mn)  n_mn = i_blue;
    end

    logic [CB-1:0]       r_a_mx, r_a_mn, r_a_p, r_a_n;
    rgbhsv_pkg::t_sector r_a_sect;

    always_ff @(posedge i_clk) begin
        r_a_mx   <= n_mx;
        r_a_mn   <= n_mn;
        r_a_p    <= n_p;
        r_a_n    <= n_n;
        r_a_sect <= n_sect;
    end

    // ---------------- stage B: delta, signed difference ----------------
    logic [CB-1:0]     r_b_delta, r_b_diff;
    rgbhsv_pkg::t_side r_b_side;

    always_ff @(posedge i_clk) begin
        r_b_delta      <= r_a_mx - r_a_mn;
        r_b_diff       <= (r_a_p >= r_a_n) ? (r_a_p - r_a_n) : (r_a_n - r_a_p);
        r_b_side.mx    <= r_a_mx;
        r_b_side.sect  <= r_a_sect;
        r_b_side.neg   <= (r_a_p < r_a_n);
        r_b_side.undef <= (r_a_mx == r_a_mn);  // grey, black included
    end

    // ---------------- stage C: numerators and denominators ----------------
    logic [NB-1:0]     r_c_hnum, r_c_snum;
    logic [DB-1:0]     r_c_hden, r_c_sden;
    rgbhsv_pkg::t_side r_c_side;

    always_ff @(posedge i_clk) begin
        r_c_hnum <= NB'(r_b_diff) * NB'(rgbhsv_pkg::HUE_SIXTH);
        // round(delta*FS/mx) = floor((2*delta*FS + mx) / (2*mx))
        r_c_snum <= NB'(r_b_delta) * NB'(2 * rgbhsv_pkg::FS) + NB'(r_b_side.mx);
        r_c_hden <= DB'(r_b_delta);
        r_c_sden <= {r_b_side.mx, 1'b0};
        r_c_side <= r_b_side;
    end

    // ---------------- divider stages ----------------
    logic [QB-1:0] s_hue_quo, s_sat_quo;
    logic          s_hue_rem_nz, s_sat_rem_nz;

    rgbhsv_div u_div_hue (
        .i_clk    (i_clk),
        .i_num    (r_c_hnum),
        .i_den    (r_c_hden),
        .o_quo    (s_hue_quo),
        .o_rem_nz (s_hue_rem_nz)
    );

    rgbhsv_div u_div_sat (
        .i_clk    (i_clk),
        .i_num    (r_c_snum),
        .i_den    (r_c_sden),
        .o_quo    (s_sat_quo),
        .o_rem_nz (s_sat_rem_nz)
    );

    // side band follows the divider stage for stage
    rgbhsv_pkg::t_side r_side_d [QB];

    always_ff @(posedge i_clk) begin
        r_side_d[0] <= r_c_side;
        for (int k = 1; k < QB; k++) begin
            r_side_d[k] <= r_side_d[k-1];
        end
    end

    // ---------------- output stage: sector offset, floor, wrap ----------------
    rgbhsv_pkg::t_side s_side;
    logic [HB:0]       n_base, n_term, n_hue_ext;
    logic [HB-1:0]     n_hue;
    logic [CB-1:0]     n_sat;

    assign s_side = r_side_d[QB-1];

    always_comb begin
        unique case (s_side.sect)
            rgbhsv_pkg::SECT_RED:   n_base = '0;
            rgbhsv_pkg::SECT_GREEN: n_base = (HB+1)'(2 * rgbhsv_pkg::HUE_SIXTH);
            rgbhsv_pkg::SECT_BLUE:  n_base = (HB+1)'(4 * rgbhsv_pkg::HUE_SIXTH);
            default:                n_base = '0;
        endcase
        // negative side: floor means the quotient rounds away from zero
        n_term = (HB+1)'(s_hue_quo[rgbhsv_pkg::TERM_BITS-1:0])
               + (HB+1)'(s_side.neg & s_hue_rem_nz);
        n_hue_ext = s_side.neg ? (n_base - n_term) : (n_base + n_term);
        if (n_hue_ext[HB]) begin
            n_hue_ext = n_hue_ext + (HB+1)'(rgbhsv_pkg::HUE_FULL);
        end
        n_hue = s_side.undef ? '0 : n_hue_ext[HB-1:0];
        // saturation never exceeds full scale, and an exact half rounds up
        n_sat = s_side.undef ? '0 : s_sat_quo[CB-1:0];
    end

    logic [HB-1:0] r_out_hue;
    logic          r_out_undef;
    logic [CB-1:0] r_out_sat, r_out_mx;

    always_ff @(posedge i_clk) begin
        r_out_hue   <= n_hue;
        r_out_undef <= s_side.undef;
        r_out_sat   <= n_sat;
        r_out_mx    <= s_side.mx;
    end

    assign o_valid         = r_vld[PD-1];
    assign o_hue           = r_out_hue;
    assign o_hue_undefined = r_out_undef;
    assign o_saturation    = r_out_sat;
    assign o_brightness    = r_out_mx;

    // the saturation remainder plays no part in rounding
    logic s_unused;
    assign s_unused = s_sat_rem_nz;

endmodule

FILE: rtl/core/rgbhsv_checker.sv
// Port-level checker for the RGB to HSV converter, bound to the top level.
// Depends on rgbhsv_pkg for the pipeline depth and hue range.
module rgbhsv_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               o_valid,
    input logic [rgbhsv_pkg::HUE_BITS-1:0]     o_hue,
    input logic                               o_hue_undefined,
    input logic [rgbhsv_pkg::CHANNEL_BITS-1:0] o_saturation,
    input logic [rgbhsv_pkg::CHANNEL_BITS-1:0] o_brightness
);

    // every result stems from an accepted transaction that ran through the whole pipeline
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, rgbhsv_pkg::PIPE_DEPTH))
        else $error("result without matching transaction");

    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hue_undefined) |-> (o_hue == '0 && o_saturation == '0))
        else $error("undefined hue with nonzero hue or saturation");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue < rgbhsv_pkg::HUE_BITS'(rgbhsv_pkg::HUE_FULL)))
        else $error("hue out of range");

    a_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hue_undefined) |-> (o_saturation != '0 && o_brightness != '0))
        else $error("colored pixel with zero saturation or brightness");

endmodule

bind rgb_to_hsv_converter_core rgbhsv_checker u_rgbhsv_checker (.*);
